### rtl/core/bpds_pkg.sv
// Shared types, constants and register codes for the byte pattern delta search.
`default_nettype none

package bpds_pkg;

  localparam int MaxPattern = 16;
  localparam int AddrBits   = 24;
  localparam int WinDepth   = MaxPattern + 1;

  // configuration field widths
  localparam int LenRegW   = 5;
  localparam int SpaceRegW = 25;
  localparam int PatBytes  = 16;
  localparam int PatW      = 8 * PatBytes;

  // APB port: 64-bit registers at 8-byte strides
  localparam int DataW  = 64;
  localparam int PaddrW = 6;
  localparam int RegSel = 3;

  localparam int EffLenW = $clog2(MaxPattern + 1);
  localparam int IdxW    = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int FillW   = $clog2(WinDepth + 1);
  localparam int SpaceW  = AddrBits + 1;

  typedef enum logic [RegSel-1:0] {
    RegMode    = 3'd0,
    RegLen     = 3'd1,
    RegPatLow  = 3'd2,
    RegPatHigh = 3'd3,
    RegSpace   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic [AddrBits-1:0] byte_address;
    logic                first;
  } in_item_t;

  typedef struct packed {
    logic                match;
    logic [AddrBits-1:0] match_address;
  } out_item_t;

  // effective configuration, already saturated
  typedef struct packed {
    logic               mode;
    logic [EffLenW-1:0] len;
    logic [EffLenW-1:0] back;
    logic [SpaceW-1:0]  space;
    logic [PatW-1:0]    pattern;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/bpds_cfg.sv
// APB register file and effective configuration for the pattern search.
`default_nettype none

module bpds_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpds_pkg::PaddrW-1:0]  paddr,
  input  logic [bpds_pkg::DataW-1:0]   pwdata,
  output logic [bpds_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output bpds_pkg::cfg_t               cfg_o
);

  logic                             mode_q;
  logic [bpds_pkg::LenRegW-1:0]     len_q;
  logic [bpds_pkg::DataW-1:0]       pat_lo_q;
  logic [bpds_pkg::DataW-1:0]       pat_hi_q;
  logic [bpds_pkg::SpaceRegW-1:0]   space_q;
  logic                             wr_en;
  bpds_pkg::reg_idx_e               reg_idx;
  logic [bpds_pkg::AddrBits:0]      full_space;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = bpds_pkg::reg_idx_e'(paddr[bpds_pkg::PaddrW-1 -: bpds_pkg::RegSel]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      len_q    <= bpds_pkg::LenRegW'(1);
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      space_q  <= bpds_pkg::SpaceRegW'(1 << bpds_pkg::AddrBits);
    end else if (wr_en) begin
      case (reg_idx)
        bpds_pkg::RegMode:    mode_q   <= pwdata[0];
        bpds_pkg::RegLen:     len_q    <= pwdata[bpds_pkg::LenRegW-1:0];
        bpds_pkg::RegPatLow:  pat_lo_q <= pwdata;
        bpds_pkg::RegPatHigh: pat_hi_q <= pwdata;
        bpds_pkg::RegSpace:   space_q  <= pwdata[bpds_pkg::SpaceRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpds_pkg::RegMode:    prdata = bpds_pkg::DataW'(mode_q);
      bpds_pkg::RegLen:     prdata = bpds_pkg::DataW'(len_q);
      bpds_pkg::RegPatLow:  prdata = pat_lo_q;
      bpds_pkg::RegPatHigh: prdata = pat_hi_q;
      bpds_pkg::RegSpace:   prdata = bpds_pkg::DataW'(space_q);
      default:              prdata = '0;
    endcase
  end

  assign full_space = {1'b1, {bpds_pkg::AddrBits{1'b0}}};

  // saturate length and space to the ranges the datapath supports
  always_comb begin
    if (len_q == '0) begin
      cfg_o.len = bpds_pkg::EffLenW'(1);
    end else if (int'(len_q) > bpds_pkg::MaxPattern) begin
      cfg_o.len = bpds_pkg::EffLenW'(bpds_pkg::MaxPattern);
    end else begin
      cfg_o.len = bpds_pkg::EffLenW'(len_q);
    end
    cfg_o.back = cfg_o.len - bpds_pkg::EffLenW'(1);
    if (space_q == '0 || 64'(space_q) > 64'(full_space)) begin
      cfg_o.space = full_space;
    end else begin
      cfg_o.space = bpds_pkg::SpaceW'(space_q);
    end
    cfg_o.mode    = mode_q;
    cfg_o.pattern = {pat_hi_q, pat_lo_q};
  end

endmodule

`default_nettype wire

### rtl/core/bpds_window.sv
// Sliding byte window with parallel exact and delta compare against the pattern.
`default_nettype none

module bpds_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  bpds_pkg::in_item_t  item_i,
  input  bpds_pkg::cfg_t      cfg_i,
  output logic                hit_o
);

  localparam int CmpW = (bpds_pkg::FillW > bpds_pkg::EffLenW + 1) ?
                        bpds_pkg::FillW : bpds_pkg::EffLenW + 1;

  logic [7:0]                  win_q [bpds_pkg::WinDepth];
  logic [7:0]                  win_d [bpds_pkg::WinDepth];
  logic [bpds_pkg::FillW-1:0]  fill_q;
  logic [bpds_pkg::FillW-1:0]  fill_d;
  logic [bpds_pkg::FillW-1:0]  fill_base;
  logic [7:0]                  sel   [bpds_pkg::MaxPattern];
  logic [7:0]                  pat_b [bpds_pkg::MaxPattern];
  logic [bpds_pkg::IdxW-1:0]   idx;
  logic [CmpW-1:0]             need;
  logic                        all_ok;

  for (genvar k = 0; k < bpds_pkg::MaxPattern; k++) begin : g_pat
    if (k < bpds_pkg::PatBytes) begin : g_in
      assign pat_b[k] = cfg_i.pattern[8*k +: 8];
    end else begin : g_zero
      assign pat_b[k] = 8'h00;
    end
  end

  // shift in the new byte, starting from an empty window on a first byte
  always_comb begin
    win_d[0] = item_i.data_byte;
    for (int i = 1; i < bpds_pkg::WinDepth; i++) begin
      win_d[i] = item_i.first ? 8'h00 : win_q[i-1];
    end
    fill_base = item_i.first ? '0 : fill_q;
    if (int'(fill_base) < bpds_pkg::WinDepth) begin
      fill_d = fill_base + bpds_pkg::FillW'(1);
    end else begin
      fill_d = fill_base;
    end
  end

  // oldest compared byte pairs with pattern byte 0
  always_comb begin
    for (int j = 0; j < bpds_pkg::MaxPattern; j++) begin
      sel[j] = cfg_i.mode ? 8'(win_d[j] - win_d[j+1]) : win_d[j];
    end
    all_ok = 1'b1;
    idx    = '0;
    for (int k = 0; k < bpds_pkg::MaxPattern; k++) begin
      if (bpds_pkg::EffLenW'(k) < cfg_i.len) begin
        idx = bpds_pkg::IdxW'(cfg_i.back - bpds_pkg::EffLenW'(k));
        if (sel[idx] != pat_b[k]) begin
          all_ok = 1'b0;
        end
      end
    end
    need  = cfg_i.mode ? CmpW'(cfg_i.len) + CmpW'(1) : CmpW'(cfg_i.len);
    hit_o = all_ok && (CmpW'(fill_d) >= need);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bpds_pkg::WinDepth; i++) begin
        win_q[i] <= 8'h00;
      end
      fill_q <= '0;
    end else if (take_i) begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bpds_wrap.sv
// Pipelined address wrap: restoring modulo, one address bit per stage, then start offset.
`default_nettype none

module bpds_wrap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          hit_i,
  input  logic [bpds_pkg::AddrBits-1:0] addr_i,
  input  bpds_pkg::cfg_t                cfg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bpds_pkg::out_item_t           out_data_o
);

  localparam int AW   = bpds_pkg::AddrBits;
  localparam int NSt  = AW + 2;
  localparam int Last = NSt - 1;

  logic          vld_q    [NSt];
  logic          can_load [NSt];
  logic          hit_q    [NSt];
  logic [AW-1:0] addr_q   [NSt];
  logic [AW-1:0] ra_q     [NSt];
  logic [AW-1:0] rb_q     [NSt];
  logic [AW-1:0] ra_d     [NSt];
  logic [AW-1:0] rb_d     [NSt];
  logic [AW-1:0] back_ext;

  assign back_ext = AW'(cfg_i.back);

  // a stage takes new data when empty or when the one after it moves on
  assign can_load[Last] = !vld_q[Last] || out_ready_i;
  for (genvar s = 0; s < Last; s++) begin : g_rdy
    assign can_load[s] = !vld_q[s] || can_load[s+1];
  end
  assign in_ready_o = can_load[0];

  assign ra_d[0] = '0;
  assign rb_d[0] = '0;

  for (genvar s = 1; s <= AW; s++) begin : g_step
    logic [AW:0] ta;
    logic [AW:0] tb;
    logic [AW:0] ma;
    logic [AW:0] mb;
    always_comb begin
      ta = {ra_q[s-1], addr_q[s-1][AW-s]};
      tb = {rb_q[s-1], back_ext[AW-s]};
      ma = (ta >= cfg_i.space) ? ta - cfg_i.space : ta;
      mb = (tb >= cfg_i.space) ? tb - cfg_i.space : tb;
      ra_d[s] = ma[AW-1:0];
      rb_d[s] = mb[AW-1:0];
    end
  end

  // step back to the start of the run, wrapping below zero
  logic [AW:0] start_sum;
  always_comb begin
    start_sum = {1'b0, ra_q[Last-1]} - {1'b0, rb_q[Last-1]};
    if (ra_q[Last-1] < rb_q[Last-1]) begin
      start_sum = start_sum + cfg_i.space;
    end
    ra_d[Last] = start_sum[AW-1:0];
    rb_d[Last] = rb_q[Last-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSt; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      if (can_load[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NSt; s++) begin
        if (can_load[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load[0] && in_valid_i) begin
      hit_q[0]  <= hit_i;
      addr_q[0] <= addr_i;
      ra_q[0]   <= ra_d[0];
      rb_q[0]   <= rb_d[0];
    end
    for (int s = 1; s < NSt; s++) begin
      if (can_load[s] && vld_q[s-1]) begin
        hit_q[s]  <= hit_q[s-1];
        addr_q[s] <= addr_q[s-1];
        ra_q[s]   <= ra_d[s];
        rb_q[s]   <= rb_d[s];
      end
    end
  end

  assign out_valid_o              = vld_q[Last];
  assign out_data_o.match         = hit_q[Last];
  assign out_data_o.match_address = hit_q[Last] ? ra_q[Last] : '0;

endmodule

`default_nettype wire

### rtl/core/byte_pattern_delta_search.sv
// Top level of the streaming byte pattern search, exact or relative delta.
//
// Bytes enter on the input channel (valid/ready) with their address and a
// first flag that empties the window before the byte goes in. Every transfer
// gives exactly one result on the output channel: a match flag and, on a
// match, the start address of the run wrapped to the space size, else zero.
// The window and the compare against the pattern are updated on the input
// transfer itself; the address wrap runs in a pipeline of an input register,
// one restoring modulo stage per address bit and a start-offset stage that
// drives the output. Throughput is one item per cycle while the receiver
// keeps taking results. When the receiver stalls, results back up
// stage by stage; input is still taken while any stage of the pipeline is
// free, and stops only once every stage holds an item.
// Reset empties the window and the pipeline and restores the registers to
// exact mode, length 1, zero pattern and the full address space. The user
// must write registers over APB only with no item in flight; not enforced.
`default_nettype none

module byte_pattern_delta_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bpds_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bpds_pkg::out_item_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpds_pkg::PaddrW-1:0]  paddr,
  input  logic [bpds_pkg::DataW-1:0]   pwdata,
  output logic [bpds_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  bpds_pkg::cfg_t cfg;
  logic           take;
  logic           hit;

  assign take = in_valid_i && in_ready_o;

  bpds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpds_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_data_i),
    .cfg_i  (cfg),
    .hit_o  (hit)
  );

  bpds_wrap u_wrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .hit_i       (hit),
    .addr_i      (in_data_i.byte_address),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
